// ===== rtl/plfr_pkg.sv =====
`timescale 1ns / 1ps

package plfr_pkg;

  localparam int VW   = 32;
  localparam int COMP = 5;
  localparam int DW   = VW + 1;
  localparam int SW   = VW + 2;
  localparam int LO   = (DW + 1) / 2;
  localparam int HI   = DW - LO;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int QB   = DW + 1;
  localparam int CW   = $clog2(QB + 1);
  localparam int XW   = VW + 2;

  typedef struct packed {
    logic signed [VW-1:0] cell_value_0;
    logic signed [VW-1:0] cell_value_1;
    logic signed [VW-1:0] cell_value_2;
    logic signed [VW-1:0] cell_value_3;
    logic signed [VW-1:0] cell_value_4;
    logic                 row_start;
    logic                 row_end;
  } in_t;

  typedef struct packed {
    logic signed [VW-1:0] lower_face_0;
    logic signed [VW-1:0] lower_face_1;
    logic signed [VW-1:0] lower_face_2;
    logic signed [VW-1:0] lower_face_3;
    logic signed [VW-1:0] lower_face_4;
    logic signed [VW-1:0] upper_face_0;
    logic signed [VW-1:0] upper_face_1;
    logic signed [VW-1:0] upper_face_2;
    logic signed [VW-1:0] upper_face_3;
    logic signed [VW-1:0] upper_face_4;
    logic                 last_of_row;
  } out_t;

  typedef struct packed {
    logic [COMP-1:0][VW-1:0] m;
    logic [COMP-1:0][VW-1:0] c;
    logic [COMP-1:0][VW-1:0] p;
    logic                    last;
  } job_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
  } lane_ctl_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MUL_LO   = 6'b000010,
    ST_MUL_HI   = 6'b000100,
    ST_DIV_INIT = 6'b001000,
    ST_DIV      = 6'b010000,
    ST_DONE     = 6'b100000
  } back_state_e;

  function automatic logic signed [XW-1:0] clamp(input logic signed [XW-1:0] v,
                                                 input logic signed [XW-1:0] x,
                                                 input logic signed [XW-1:0] y);
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] r;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    r  = v;
    if (r < lo) r = lo;
    if (hi < r) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/plm_limited_face_reconstruction.sv =====
`timescale 1ns / 1ps

// Limited piecewise-linear face reconstruction along a row. Cells enter one
// per transaction; the first two cells of a row (or after a row end) only fill
// the window, every later cell yields the lower and upper faces of the
// previous cell. Cells that yield no result are taken in one per cycle while
// the queue is not full. The back end works on one result at a time: it loads
// the cells, forms the product in two halves, then runs the bit-serial
// harmonic-slope divider, one quotient bit per cycle, all five components in
// parallel. A two-entry queue, the result being worked on and the output
// register let up to four results be in flight before the input stalls.
module plm_limited_face_reconstruction (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  plfr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output plfr_pkg::out_t out_data_o
);

  logic           push, full, job_valid, job_pop;
  plfr_pkg::job_t job_in, job_out;

  plfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  plfr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .job_o   (job_out)
  );

  plfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/plfr_front.sv =====
`timescale 1ns / 1ps

module plfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  plfr_pkg::in_t in_data_i,
  input  logic          full_i,
  output logic          push_o,
  output plfr_pkg::job_t job_o
);

  logic [plfr_pkg::COMP-1:0][plfr_pkg::VW-1:0] m_q, c_q, in_vals;
  logic [1:0] seen_q, seen_d, seen_eff;
  logic       accept;

  assign in_vals[0] = in_data_i.cell_value_0;
  assign in_vals[1] = in_data_i.cell_value_1;
  assign in_vals[2] = in_data_i.cell_value_2;
  assign in_vals[3] = in_data_i.cell_value_3;
  assign in_vals[4] = in_data_i.cell_value_4;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign seen_eff   = in_data_i.row_start ? 2'd0 : seen_q;
  assign push_o     = accept && (seen_eff == 2'd2);

  assign job_o.m    = m_q;
  assign job_o.c    = c_q;
  assign job_o.p    = in_vals;
  assign job_o.last = in_data_i.row_end;

  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      seen_d = (seen_eff == 2'd2) ? seen_eff : seen_eff + 2'd1;
      if (in_data_i.row_end) seen_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q <= c_q;
      c_q <= in_vals;
    end
  end

endmodule

// ===== rtl/plfr_fifo.sv =====
`timescale 1ns / 1ps

module plfr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  plfr_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output plfr_pkg::job_t job_o
);

  plfr_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== rtl/plfr_lane.sv =====
`timescale 1ns / 1ps

module plfr_lane (
  input  logic                     clk_i,
  input  plfr_pkg::lane_ctl_t      ctl_i,
  input  logic [plfr_pkg::VW-1:0]  m_i,
  input  logic [plfr_pkg::VW-1:0]  c_i,
  input  logic [plfr_pkg::VW-1:0]  p_i,
  output logic [plfr_pkg::VW-1:0]  lower_o,
  output logic [plfr_pkg::VW-1:0]  upper_o
);

  localparam int VW = plfr_pkg::VW;
  localparam int DW = plfr_pkg::DW;
  localparam int SW = plfr_pkg::SW;
  localparam int LO = plfr_pkg::LO;
  localparam int HI = plfr_pkg::HI;
  localparam int PW = plfr_pkg::PW;
  localparam int NW = plfr_pkg::NW;
  localparam int QB = plfr_pkg::QB;
  localparam int XW = plfr_pkg::XW;

  logic signed [DW-1:0] l_d, r_d;
  logic                 pos_d, neg_d;
  logic [DW-1:0]        a_d, b_d;

  logic [VW-1:0]        m_q, c_q, p_q;
  logic                 pos_q, neg_q;
  logic [DW-1:0]        a_q, b_q;
  logic [PW-1:0]        prod_q;
  logic [SW-1:0]        rem_q, den_q;
  logic [QB-1:0]        num_q, quo_q;

  logic [DW+LO-1:0]     pp_lo;
  logic [DW+HI-1:0]     pp_hi;
  logic [NW-1:0]        num_full;
  logic [SW:0]          trial;
  logic                 ge;

  logic signed [XW-1:0] mx, cx, px, hx, lower_raw, upper_raw, lower_c, upper_c;

  always_comb begin
    l_d   = $signed({c_i[VW-1], c_i}) - $signed({m_i[VW-1], m_i});
    r_d   = $signed({p_i[VW-1], p_i}) - $signed({c_i[VW-1], c_i});
    pos_d = !l_d[DW-1] && (l_d != '0) && !r_d[DW-1] && (r_d != '0);
    neg_d = l_d[DW-1] && r_d[DW-1];
    a_d   = '0;
    b_d   = '0;
    if (pos_d) begin
      a_d = l_d;
      b_d = r_d;
    end else if (neg_d) begin
      a_d = -l_d;
      b_d = -r_d;
    end
  end

  assign pp_lo    = a_q * b_q[LO-1:0];
  assign pp_hi    = a_q * b_q[DW-1:LO];
  assign num_full = {prod_q, 1'b0};
  assign trial    = {rem_q, num_q[QB-1]};
  assign ge       = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      m_q   <= m_i;
      c_q   <= c_i;
      p_q   <= p_i;
      pos_q <= pos_d;
      neg_q <= neg_d;
      a_q   <= a_d;
      b_q   <= b_d;
    end
    if (ctl_i.mul_lo) prod_q <= PW'(pp_lo);
    if (ctl_i.mul_hi) prod_q <= prod_q + {pp_hi, LO'(0)};
    if (ctl_i.div_init) begin
      rem_q <= SW'(num_full[NW-1:QB]);
      num_q <= num_full[QB-1:0];
      den_q <= SW'(a_q) + SW'(b_q);
      quo_q <= '0;
    end
    if (ctl_i.div_step) begin
      rem_q <= ge ? SW'(trial - {1'b0, den_q}) : trial[SW-1:0];
      num_q <= {num_q[QB-2:0], 1'b0};
      quo_q <= {quo_q[QB-2:0], ge};
    end
  end

  always_comb begin
    mx = $signed({{(XW-VW){m_q[VW-1]}}, m_q});
    cx = $signed({{(XW-VW){c_q[VW-1]}}, c_q});
    px = $signed({{(XW-VW){p_q[VW-1]}}, p_q});
    hx = $signed(XW'(quo_q[QB-1:1]));
    if (pos_q) begin
      lower_raw = cx - hx;
      upper_raw = cx + hx;
    end else if (neg_q) begin
      lower_raw = cx + hx;
      upper_raw = cx - hx;
    end else begin
      lower_raw = cx;
      upper_raw = cx;
    end
    lower_c = plfr_pkg::clamp(lower_raw, mx, cx);
    upper_c = plfr_pkg::clamp(upper_raw, cx, px);
  end

  assign lower_o = lower_c[VW-1:0];
  assign upper_o = upper_c[VW-1:0];

endmodule

// ===== rtl/plfr_back.sv =====
`timescale 1ns / 1ps

module plfr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  plfr_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output plfr_pkg::out_t out_data_o
);

  plfr_pkg::back_state_e state_q, state_d;
  plfr_pkg::lane_ctl_t   ctl;
  logic [plfr_pkg::CW-1:0] cnt_q, cnt_d;
  logic                    last_q;
  logic                    out_valid_q, out_load;
  plfr_pkg::out_t          out_q;
  logic [plfr_pkg::COMP-1:0][plfr_pkg::VW-1:0] lower, upper;

  for (genvar g = 0; g < plfr_pkg::COMP; g++) begin : g_lane
    plfr_lane u_lane (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .m_i     (job_i.m[g]),
      .c_i     (job_i.c[g]),
      .p_i     (job_i.p[g]),
      .lower_o (lower[g]),
      .upper_o (upper[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ctl      = '0;
    out_load = 1'b0;
    case (state_q)
      plfr_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          ctl.load = 1'b1;
          state_d  = plfr_pkg::ST_MUL_LO;
        end
      end
      plfr_pkg::ST_MUL_LO: begin
        ctl.mul_lo = 1'b1;
        state_d    = plfr_pkg::ST_MUL_HI;
      end
      plfr_pkg::ST_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_d    = plfr_pkg::ST_DIV_INIT;
      end
      plfr_pkg::ST_DIV_INIT: begin
        ctl.div_init = 1'b1;
        cnt_d        = '0;
        state_d      = plfr_pkg::ST_DIV;
      end
      plfr_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == plfr_pkg::CW'(plfr_pkg::QB - 1)) state_d = plfr_pkg::ST_DONE;
      end
      plfr_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = plfr_pkg::ST_IDLE;
        end
      end
      default: state_d = plfr_pkg::ST_IDLE;
    endcase
  end

  assign job_pop_o   = ctl.load;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plfr_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load) last_q <= job_i.last;
    if (out_load) begin
      out_q.lower_face_0 <= lower[0];
      out_q.lower_face_1 <= lower[1];
      out_q.lower_face_2 <= lower[2];
      out_q.lower_face_3 <= lower[3];
      out_q.lower_face_4 <= lower[4];
      out_q.upper_face_0 <= upper[0];
      out_q.upper_face_1 <= upper[1];
      out_q.upper_face_2 <= upper[2];
      out_q.upper_face_3 <= upper[3];
      out_q.upper_face_4 <= upper[4];
      out_q.last_of_row  <= last_q;
    end
  end

endmodule

// ===== rtl/plfr_checker.sv =====
`timescale 1ns / 1ps

module plfr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input plfr_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input plfr_pkg::out_t out_data_o
);

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // at most the output register and one finished result can leave back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 out_acc |=> !out_acc)
    else $error("three results in consecutive cycles");

endmodule

bind plm_limited_face_reconstruction plfr_checker u_plfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int NCOMP = 5;
  localparam int WATCH_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  plfr_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  plfr_pkg::out_t out_data_o;

  always #6 clk_i = ~clk_i;

  plm_limited_face_reconstruction DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // window of the predictor
  logic signed [31:0] older_cell [NCOMP];
  logic signed [31:0] middle_cell [NCOMP];
  int row_fill = 0;
  plfr_pkg::in_t pending_cells [$];
  plfr_pkg::out_t expected_faces [$];
  int errors = 0;
  bit quiet = 0;
  int watch = 0;

  function automatic logic [31:0] cell_field(plfr_pkg::in_t c, int n);
    case (n)
      0: return c.cell_value_0;
      1: return c.cell_value_1;
      2: return c.cell_value_2;
      3: return c.cell_value_3;
      default: return c.cell_value_4;
    endcase
  endfunction

  function automatic logic signed [33:0] clamp_to(logic signed [33:0] v,
      logic signed [33:0] x, logic signed [33:0] y);
    logic signed [33:0] lo, hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    if (v < lo) v = lo;
    if (hi < v) v = hi;
    return v;
  endfunction

  task automatic predict_faces(plfr_pkg::in_t c);
    plfr_pkg::out_t r;
    logic signed [33:0] m, ce, p, lf, uf;
    logic [33:0] a, b, mn, mag, halfc, hm, h;
    logic [67:0] num;
    int sgn;
    logic [31:0] lows [NCOMP];
    logic [31:0] ups [NCOMP];
    if (c.row_start) row_fill = 0;
    if (row_fill >= 2) begin
      for (int n = 0; n < NCOMP; n++) begin
        m = older_cell[n];
        ce = middle_cell[n];
        p = $signed(cell_field(c, n));
        sgn = 0; a = 0; b = 0; mag = 0;
        if (m < ce && ce < p) begin
          sgn = 1; a = ce - m; b = p - ce;
        end else if (ce < m && p < ce) begin
          sgn = -1; a = m - ce; b = ce - p;
        end
        if (sgn != 0) begin
          mn = (a < b) ? a : b;
          halfc = (a + b) >> 1;
          num = 68'(a) * 68'(b) * 2;
          hm = 34'(num / 68'(a + b));
          mag = mn << 1;
          if (halfc < mag) mag = halfc;
          if (hm < mag) mag = hm;
        end
        h = mag >> 1;
        lf = (sgn > 0) ? ce - $signed(h) : ce + $signed(h);
        uf = (sgn > 0) ? ce + $signed(h) : ce - $signed(h);
        lows[n] = 32'(clamp_to(lf, m, ce));
        ups[n] = 32'(clamp_to(uf, ce, p));
      end
      r.lower_face_0 = lows[0]; r.lower_face_1 = lows[1]; r.lower_face_2 = lows[2];
      r.lower_face_3 = lows[3]; r.lower_face_4 = lows[4];
      r.upper_face_0 = ups[0]; r.upper_face_1 = ups[1]; r.upper_face_2 = ups[2];
      r.upper_face_3 = ups[3]; r.upper_face_4 = ups[4];
      r.last_of_row = c.row_end;
      expected_faces.push_back(r);
    end
    for (int n = 0; n < NCOMP; n++) begin
      older_cell[n] = middle_cell[n];
      middle_cell[n] = cell_field(c, n);
    end
    if (row_fill < 2) row_fill++;
    if (c.row_end) row_fill = 0;
  endtask

  function automatic logic [31:0] rand_value(logic [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return base + $urandom_range(0, 8) - 4;
      2: return base;
      3: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return base + ($urandom & 32'h000fffff) - 32'h00080000;
    endcase
  endfunction

  function automatic plfr_pkg::in_t make_cell(logic [31:0] v0, logic [31:0] v1,
      logic [31:0] v2, logic [31:0] v3, logic [31:0] v4, bit st, bit en);
    plfr_pkg::in_t c;
    c.cell_value_0 = v0; c.cell_value_1 = v1; c.cell_value_2 = v2;
    c.cell_value_3 = v3; c.cell_value_4 = v4;
    c.row_start = st; c.row_end = en;
    return c;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cells.size() > 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
          in_data_i <= pending_cells.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 12);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    plfr_pkg::out_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) watch <= 0;
      else watch <= watch + 1;
      if (in_valid_i && !in_stall_o) predict_faces(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_faces.size() == 0) begin
          $error("unexpected transaction %h", out_data_o);
          errors++;
        end else begin
          e = expected_faces.pop_front();
          if (out_data_o.lower_face_0 !== e.lower_face_0) begin
            $error("lower_face_0 exp %h got %h", e.lower_face_0, out_data_o.lower_face_0);
            errors++;
          end
          if (out_data_o.lower_face_1 !== e.lower_face_1) begin
            $error("lower_face_1 exp %h got %h", e.lower_face_1, out_data_o.lower_face_1);
            errors++;
          end
          if (out_data_o.lower_face_2 !== e.lower_face_2) begin
            $error("lower_face_2 exp %h got %h", e.lower_face_2, out_data_o.lower_face_2);
            errors++;
          end
          if (out_data_o.lower_face_3 !== e.lower_face_3) begin
            $error("lower_face_3 exp %h got %h", e.lower_face_3, out_data_o.lower_face_3);
            errors++;
          end
          if (out_data_o.lower_face_4 !== e.lower_face_4) begin
            $error("lower_face_4 exp %h got %h", e.lower_face_4, out_data_o.lower_face_4);
            errors++;
          end
          if (out_data_o.upper_face_0 !== e.upper_face_0) begin
            $error("upper_face_0 exp %h got %h", e.upper_face_0, out_data_o.upper_face_0);
            errors++;
          end
          if (out_data_o.upper_face_1 !== e.upper_face_1) begin
            $error("upper_face_1 exp %h got %h", e.upper_face_1, out_data_o.upper_face_1);
            errors++;
          end
          if (out_data_o.upper_face_2 !== e.upper_face_2) begin
            $error("upper_face_2 exp %h got %h", e.upper_face_2, out_data_o.upper_face_2);
            errors++;
          end
          if (out_data_o.upper_face_3 !== e.upper_face_3) begin
            $error("upper_face_3 exp %h got %h", e.upper_face_3, out_data_o.upper_face_3);
            errors++;
          end
          if (out_data_o.upper_face_4 !== e.upper_face_4) begin
            $error("upper_face_4 exp %h got %h", e.upper_face_4, out_data_o.upper_face_4);
            errors++;
          end
          if (out_data_o.last_of_row !== e.last_of_row) begin
            $error("last_of_row exp %b got %b", e.last_of_row, out_data_o.last_of_row);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (watch >= WATCH_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] base [NCOMP];
    logic [31:0] v [NCOMP];
    int len, total;
    for (int n = 0; n < NCOMP; n++) begin
      older_cell[n] = '0;
      middle_cell[n] = '0;
    end
    // extremes, monotone ramps, sign disagreement, flat, short rows
    pending_cells.push_back(make_cell(32'h80000000, 0, 5, 32'h7fffffff, 1, 1, 0));
    pending_cells.push_back(make_cell(0, 0, 10, 0, 2, 0, 0));
    pending_cells.push_back(make_cell(32'h7fffffff, 0, 15, 32'h80000000, 4, 0, 0));
    pending_cells.push_back(make_cell(32'h80000000, 3, 30, 32'h7fffffff, 4, 0, 0));
    pending_cells.push_back(make_cell(32'h7fffffff, 3, 31, 32'h80000000, 100, 0, 1));
    pending_cells.push_back(make_cell(1, 2, 3, 4, 5, 0, 0));
    pending_cells.push_back(make_cell(7, 2, 1, 4, 5, 0, 0));
    pending_cells.push_back(make_cell(9, 2, 0, 3, 5, 0, 0));
    pending_cells.push_back(make_cell(20, 9, 32'hffffffff, 3, 5, 1, 0));
    pending_cells.push_back(make_cell(1, 1, 1, 1, 1, 1, 1));
    pending_cells.push_back(make_cell(2, 2, 2, 2, 2, 0, 0));
    pending_cells.push_back(make_cell(3, 3, 3, 3, 3, 0, 1));
    pending_cells.push_back(make_cell(32'hfffffff0, 0, 9, 5, 5, 0, 0));
    pending_cells.push_back(make_cell(32'hfffffff8, 1, 8, 6, 4, 0, 0));
    pending_cells.push_back(make_cell(32'hffffffff, 3, 2, 8, 3, 0, 0));
    pending_cells.push_back(make_cell(32'h00010000, 7, 1, 9, 2, 0, 1));
    #(12 * 10);
    @(negedge clk_i);
    rst_ni = 1'b1;
    total = pending_cells.size();
    while (total < 1700) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      for (int n = 0; n < NCOMP; n++) base[n] = $urandom;
      for (int k = 0; k < len; k++) begin
        for (int n = 0; n < NCOMP; n++) begin
          v[n] = rand_value(base[n]);
          base[n] = v[n];
        end
        pending_cells.push_back(make_cell(v[0], v[1], v[2], v[3], v[4],
            (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 40) == 0),
            (k == len - 1) ? ($urandom_range(0, 4) != 0) : 1'b0));
      end
      total += len;
      if (total > 600 && total < 640) quiet = 1;
      if (total > 900) quiet = 0;
      while (pending_cells.size() > 64) @(posedge clk_i);
    end
    while (pending_cells.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_faces.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== plm_limited_face_reconstruction.f =====
rtl/plfr_pkg.sv
rtl/plfr_front.sv
rtl/plfr_fifo.sv
rtl/plfr_lane.sv
rtl/plfr_back.sv
rtl/plm_limited_face_reconstruction.sv
rtl/plfr_checker.sv
tb/tb_top.sv
